FILE: src/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
`timescale 1ns / 1ps
`default_nettype none
package mcmp_pkg;

  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
  localparam logic [3:0] NIB_SYSTEM        = 4'hF;
  localparam logic [3:0] NIB_PROG_CHANGE   = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_MIN          = 4'h8;
  localparam logic [3:0] KIND_MAX          = 4'hE;

  typedef enum logic [2:0] {
    CMD_DATA        = 3'd0,
    CMD_CHAN_STATUS = 3'd1,
    CMD_SYSEX_START = 3'd2,
    CMD_SYSEX_END   = 3'd3,
    CMD_COMMON      = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0] msg_kind;
    logic [3:0] msg_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } res_t;

endpackage
`default_nettype wire

FILE: src/midi_channel_message_parser_core.sv
// MIDI byte stream parser with running status; emits complete channel messages.
// One MIDI byte is taken per clock cycle, back to back, as long as in_full is low.
// Real-time bytes are dropped at the front; every other byte is classified and
// queued for the back end, which updates the running status for each byte and
// queues a finished message for the result side. A message reaches the result
// ports once its last byte has gone through the command queue and the back end
// into the result queue. The back end takes one byte per cycle while that queue
// has room. Either side may stall; the two queues absorb the difference.
`timescale 1ns / 1ps
`default_nettype none
module midi_channel_message_parser_core
  import mcmp_pkg::*;
#(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_full,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [3:0]      out_msg_kind,
  output logic [3:0]      out_msg_channel,
  output logic [6:0]      out_first_data,
  output logic [6:0]      out_second_data
);

  cmd_t cmd_wr, cmd_rd;
  res_t res_wr, res_rd;
  logic cmd_push, cmd_pop, cmd_empty;
  logic res_push, res_full;

  mcmp_front u_front (
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .cmd_full   (in_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_wr)
  );

  mcmp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wr),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_rd),
    .empty (cmd_empty)
  );

  mcmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr)
  );

  mcmp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rd),
    .empty (out_empty)
  );

  assign out_msg_kind    = res_rd.msg_kind;
  assign out_msg_channel = res_rd.msg_channel;
  assign out_first_data  = res_rd.first_data;
  assign out_second_data = res_rd.second_data;

  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result request pushed into full queue");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_wr.msg_kind >= KIND_MIN && res_wr.msg_kind <= KIND_MAX))
    else $error("emitted message kind outside channel range");

  a_realtime_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_rx_byte >= BYTE_REALTIME_MIN) |-> !cmd_push)
    else $error("real-time byte reached command queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
`default_nettype wire

FILE: src/mcmp_fifo.sv
// Small register-based queue with count, used for the parser's command and result queues.
`timescale 1ns / 1ps
`default_nettype none
module mcmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: src/mcmp_front.sv
// Front end: classifies received bytes and drops real-time bytes.
`timescale 1ns / 1ps
`default_nettype none
module mcmp_front
  import mcmp_pkg::*;
(
  input  wire logic       in_push,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       cmd_full,
  output logic            cmd_push,
  output cmd_t            cmd
);

  logic rt_byte;

  assign rt_byte = (in_rx_byte >= BYTE_REALTIME_MIN);
  // real-time bytes are accepted but never reach the back end
  assign cmd_push = in_push && !cmd_full && !rt_byte;

  always_comb begin
    cmd.value = in_rx_byte;
    cmd.kind  = CMD_DATA;
    if (in_rx_byte[7]) begin
      if (in_rx_byte == BYTE_SYSEX_START) begin
        cmd.kind = CMD_SYSEX_START;
      end else if (in_rx_byte == BYTE_SYSEX_END) begin
        cmd.kind = CMD_SYSEX_END;
      end else if (in_rx_byte[7:4] == NIB_SYSTEM) begin
        cmd.kind = CMD_COMMON;
      end else begin
        cmd.kind = CMD_CHAN_STATUS;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/mcmp_back.sv
// Back end: running-status state and message assembly.
`timescale 1ns / 1ps
`default_nettype none
module mcmp_back
  import mcmp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_push,
  output res_t      res
);

  logic [7:0] status_r, status_nxt;
  logic       have_first_r, have_first_nxt;
  logic       needs_two_r, needs_two_nxt;
  logic       in_excl_r, in_excl_nxt;
  logic [6:0] held_first_r, held_first_nxt;
  logic       take;

  assign take    = !cmd_empty && !res_full;
  assign cmd_pop = take;

  always_comb begin
    status_nxt      = status_r;
    have_first_nxt  = have_first_r;
    needs_two_nxt   = needs_two_r;
    in_excl_nxt     = in_excl_r;
    held_first_nxt  = held_first_r;
    res_push        = 1'b0;
    res.msg_kind    = status_r[7:4];
    res.msg_channel = status_r[3:0];
    res.first_data  = cmd.value[6:0];
    res.second_data = '0;
    if (take) begin
      unique case (cmd.kind)
        CMD_SYSEX_START: begin
          in_excl_nxt = 1'b1;
          status_nxt  = '0;
        end
        CMD_SYSEX_END: begin
          in_excl_nxt = 1'b0;
        end
        CMD_COMMON: begin
          status_nxt = '0;
        end
        CMD_CHAN_STATUS: begin
          in_excl_nxt    = 1'b0;
          status_nxt     = cmd.value;
          have_first_nxt = 1'b0;
          needs_two_nxt  = !(cmd.value[7:4] == NIB_PROG_CHANGE ||
                             cmd.value[7:4] == NIB_CHAN_PRESSURE);
        end
        CMD_DATA: begin
          // dropped inside sysex or with no running status
          if (!in_excl_r && status_r != '0) begin
            if (!have_first_r) begin
              if (!needs_two_r) begin
                res_push = 1'b1;
              end else begin
                held_first_nxt = cmd.value[6:0];
                have_first_nxt = 1'b1;
              end
            end else begin
              res_push        = 1'b1;
              res.first_data  = held_first_r;
              res.second_data = cmd.value[6:0];
              have_first_nxt  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r     <= '0;
      have_first_r <= 1'b0;
      needs_two_r  <= 1'b0;
      in_excl_r    <= 1'b0;
      held_first_r <= '0;
    end else begin
      status_r     <= status_nxt;
      have_first_r <= have_first_nxt;
      needs_two_r  <= needs_two_nxt;
      in_excl_r    <= in_excl_nxt;
      held_first_r <= held_first_nxt;
    end
  end

endmodule
`default_nettype wire
